[design/m3h_pkg.sv]
// Shared constants, types and helpers for the streamed MurmurHash3 x86_32 hasher.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package m3h_pkg;

	localparam int unsigned HashW  = 32;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 2;

	localparam logic [HashW-1:0] C1 = 32'hcc9e2d51;
	localparam logic [HashW-1:0] C2 = 32'h1b873593;
	localparam logic [HashW-1:0] C3 = 32'he6546b64;
	localparam logic [HashW-1:0] C4 = 32'h85ebca6b;
	localparam logic [HashW-1:0] C5 = 32'hc2b2ae35;

	localparam int unsigned RotK   = 15;
	localparam int unsigned RotH   = 13;
	localparam int unsigned ShFin1 = 16;
	localparam int unsigned ShFin2 = 13;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_K1   = 7'b0000010,
		ST_K2   = 7'b0000100,
		ST_HMIX = 7'b0001000,
		ST_F1   = 7'b0010000,
		ST_F2   = 7'b0100000,
		ST_F3   = 7'b1000000
	} state_t;

	// finished digest offered by the sequencer to the output register
	typedef struct packed {
		logic             valid;
		logic [HashW-1:0] digest;
	} res_t;

	function automatic logic [HashW-1:0] rotl(input logic [HashW-1:0] x, input int unsigned r);
		rotl = (x << r) | (x >> (HashW - r));
	endfunction

endpackage

`default_nettype wire

[design/m3h_msg_if.sv]
// Input channel carrying one message byte item per handshake.
// Uses m3h_pkg for field widths.
`default_nettype none

interface m3h_msg_if;
	logic                      valid;
	logic                      ready;
	logic [m3h_pkg::ByteW-1:0] data_byte;
	logic                      byte_present;
	logic                      finish;

	modport source (output valid, output data_byte, output byte_present, output finish,
		input ready);
	modport sink (input valid, input data_byte, input byte_present, input finish,
		output ready);
endinterface

`default_nettype wire

[design/m3h_res_if.sv]
// Output channel carrying one finalized digest item per handshake.
// Uses m3h_pkg for the digest width.
`default_nettype none

interface m3h_res_if;
	logic                      valid;
	logic                      ready;
	logic [m3h_pkg::HashW-1:0] digest;

	modport source (output valid, output digest, input ready);
	modport sink (input valid, input digest, output ready);
endinterface

`default_nettype wire

[design/m3h_mul.sv]
// Shared 32x32 multiplier keeping the low product word in a register.
// Depends on m3h_pkg for the word width.
`default_nettype none

module m3h_mul (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [m3h_pkg::HashW-1:0] a,
	input  wire logic [m3h_pkg::HashW-1:0] b,
	output logic      [m3h_pkg::HashW-1:0] prod
);

	logic [m3h_pkg::HashW-1:0] prod_q;

	// hold the product while idle so later states can still read it
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

[design/m3h_seq.sv]
// Sequencer and hash state: absorbs bytes, drives the shared multiplier
// through block mix and finalizer steps. Depends on m3h_pkg and m3h_msg_if.
`default_nettype none

module m3h_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	m3h_msg_if.sink                        msg,
	input  wire logic                      cfg_we,
	input  wire logic [m3h_pkg::HashW-1:0] cfg_wdata,
	output logic                           mul_en,
	output logic      [m3h_pkg::HashW-1:0] mul_a,
	output logic      [m3h_pkg::HashW-1:0] mul_b,
	input  wire logic [m3h_pkg::HashW-1:0] prod,
	input  wire logic                      take,
	output m3h_pkg::res_t                  res
);

	m3h_pkg::state_t             state_q;
	logic [m3h_pkg::HashW-1:0]   seed_q;
	logic [m3h_pkg::HashW-1:0]   h_q;
	logic [m3h_pkg::HashW-1:0]   part_q;
	logic [m3h_pkg::HashW-1:0]   k_q;
	logic [m3h_pkg::CountW-1:0]  cnt_q;
	logic [m3h_pkg::HashW-1:0]   len_q;
	logic                        started_q;
	logic                        tail_q;
	logic                        fin_q;

	logic                        acc;
	logic                        blk_done;
	logic [m3h_pkg::CountW-1:0]  cnt_inc;
	logic [m3h_pkg::CountW-1:0]  cnt_after;
	logic [m3h_pkg::HashW-1:0]   part_nxt;
	logic [m3h_pkg::HashW-1:0]   hx;
	logic [m3h_pkg::HashW-1:0]   fx;
	logic [m3h_pkg::HashW-1:0]   gx;

	assign msg.ready = (state_q == m3h_pkg::ST_IDLE);
	assign acc       = msg.valid && msg.ready;
	assign cnt_inc   = cnt_q + 2'd1;
	assign cnt_after = msg.byte_present ? cnt_inc : cnt_q;
	assign blk_done  = msg.byte_present && (cnt_q == 2'd3);
	assign part_nxt  = msg.byte_present
		? (part_q | ({24'd0, msg.data_byte} << {cnt_q, 3'b000})) : part_q;

	assign hx = m3h_pkg::rotl(h_q ^ prod, m3h_pkg::RotH);
	assign fx = (h_q ^ len_q) ^ ((h_q ^ len_q) >> m3h_pkg::ShFin1);
	assign gx = prod ^ (prod >> m3h_pkg::ShFin2);

	always_comb begin
		mul_en = 1'b0;
		mul_a  = k_q;
		mul_b  = m3h_pkg::C1;
		unique case (state_q)
			m3h_pkg::ST_K1: begin
				mul_en = 1'b1;
			end
			m3h_pkg::ST_K2: begin
				mul_en = 1'b1;
				mul_a  = m3h_pkg::rotl(prod, m3h_pkg::RotK);
				mul_b  = m3h_pkg::C2;
			end
			m3h_pkg::ST_F1: begin
				mul_en = 1'b1;
				mul_a  = fx;
				mul_b  = m3h_pkg::C4;
			end
			m3h_pkg::ST_F2: begin
				mul_en = 1'b1;
				mul_a  = gx;
				mul_b  = m3h_pkg::C5;
			end
			default: begin
			end
		endcase
	end

	assign res.valid  = (state_q == m3h_pkg::ST_F3);
	assign res.digest = prod ^ (prod >> m3h_pkg::ShFin1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= m3h_pkg::ST_IDLE;
			seed_q    <= '0;
			h_q       <= '0;
			part_q    <= '0;
			k_q       <= '0;
			cnt_q     <= '0;
			len_q     <= '0;
			started_q <= 1'b0;
			tail_q    <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
				if (!started_q) begin
					h_q <= cfg_wdata;
				end
			end
			unique case (state_q)
				m3h_pkg::ST_IDLE: begin
					if (acc) begin
						fin_q  <= msg.finish;
						tail_q <= 1'b0;
						if (msg.byte_present) begin
							started_q <= 1'b1;
							len_q     <= len_q + 32'd1;
							cnt_q     <= cnt_inc;
						end
						if (blk_done) begin
							k_q     <= part_nxt;
							part_q  <= '0;
							state_q <= m3h_pkg::ST_K1;
						end else begin
							part_q <= part_nxt;
							if (msg.finish) begin
								if (cnt_after != 2'd0) begin
									k_q     <= part_nxt;
									tail_q  <= 1'b1;
									state_q <= m3h_pkg::ST_K1;
								end else begin
									state_q <= m3h_pkg::ST_F1;
								end
							end
						end
					end
				end
				m3h_pkg::ST_K1: state_q <= m3h_pkg::ST_K2;
				m3h_pkg::ST_K2: state_q <= m3h_pkg::ST_HMIX;
				m3h_pkg::ST_HMIX: begin
					if (tail_q) begin
						h_q     <= h_q ^ prod;
						state_q <= m3h_pkg::ST_F1;
					end else begin
						// h*5 + c3 as shift and add
						h_q     <= (hx << 2) + hx + m3h_pkg::C3;
						state_q <= fin_q ? m3h_pkg::ST_F1 : m3h_pkg::ST_IDLE;
					end
				end
				m3h_pkg::ST_F1: state_q <= m3h_pkg::ST_F2;
				m3h_pkg::ST_F2: state_q <= m3h_pkg::ST_F3;
				m3h_pkg::ST_F3: begin
					// hold the digest until the output register has room, then restart
					if (take) begin
						h_q       <= seed_q;
						part_q    <= '0;
						cnt_q     <= '0;
						len_q     <= '0;
						started_q <= 1'b0;
						state_q   <= m3h_pkg::ST_IDLE;
					end
				end
				default: state_q <= m3h_pkg::ST_IDLE;
			endcase
		end
	end

	a_res_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == m3h_pkg::ST_F3))
		else $error("digest offered outside final step");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && msg.finish) |=> (state_q != m3h_pkg::ST_IDLE))
		else $error("finish item did not start finalization");

	a_block_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == m3h_pkg::ST_HMIX) && !tail_q) |-> (cnt_q == 2'd0))
		else $error("block mix with partial bytes pending");

	a_tail_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == m3h_pkg::ST_K1) && tail_q) |-> (cnt_q != 2'd0))
		else $error("tail mix with no tail bytes");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && take) |=> ((len_q == '0) && !started_q && (state_q == m3h_pkg::ST_IDLE)))
		else $error("state not restarted after digest");

endmodule

`default_nettype wire

[design/murmur3_32_stream_hash_top.sv]
// Top level of the streamed MurmurHash3 x86_32 hasher: sequencer, shared
// multiplier and digest output register. Depends on m3h_pkg, both channel interfaces.
`default_nettype none

// One byte item per handshake, packed little-endian into 32-bit blocks.
// An item without a completed block only updates the partial block; an item
// that completes a block also runs the block mix (two multiplies) and the hash
// update one after another through the single shared multiplier, taking no new
// item meanwhile. A finish item also runs the finalizer (two multiplies plus
// the digest step), after a tail mix when tail bytes are pending. The digest
// sits in an output register, so the next message may start while it waits to
// be taken. Writing the seed between messages also reloads the running hash; a
// write in mid-message applies from the next message on.
module murmur3_32_stream_hash_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	m3h_msg_if.sink                        msg,
	m3h_res_if.source                      res,
	input  wire logic                      cfg_we,
	input  wire logic [m3h_pkg::HashW-1:0] cfg_wdata
);

	logic                      mul_en;
	logic [m3h_pkg::HashW-1:0] mul_a;
	logic [m3h_pkg::HashW-1:0] mul_b;
	logic [m3h_pkg::HashW-1:0] prod;
	logic                      take;
	m3h_pkg::res_t             seq_res;

	logic                      out_valid_q;
	logic [m3h_pkg::HashW-1:0] digest_q;

	m3h_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	m3h_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mul_en    (mul_en),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.prod      (prod),
		.take      (take),
		.res       (seq_res)
	);

	assign take = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= seq_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && seq_res.valid) begin
			digest_q <= seq_res.digest;
		end
	end

	assign res.valid  = out_valid_q;
	assign res.digest = digest_q;

endmodule

`default_nettype wire
